[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/i2c_pkg.sv]
// Types, constants and register codes of the im2col address generator.
package i2c_pkg;

	// Convolution geometry held fixed at build time
	localparam int DILATION_ROWS    = 1;
	localparam int DILATION_COLS    = 1;
	localparam int MAX_IMAGE_DIM    = 4096;
	localparam int OFFSET_BITS_DEF  = 32;

	// Field widths
	localparam int DIM_W     = 13;
	localparam int KER_W     = 5;
	localparam int PAD_W     = 4;
	localparam int STR_W     = 5;
	localparam int CH_W      = 11;
	localparam int CHIDX_W   = 10;
	localparam int TAP_W     = 4;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 3;
	localparam int IN_DATA_W = 16;

	// Limits
	localparam int MAX_CHANNELS = 1024;
	localparam int MAX_KERNEL   = 16;
	localparam int OUT_DIM_MAX  = 8191;
	localparam logic [16:0] MAX_DIM_V = 17'(MAX_IMAGE_DIM);

	// Output-size arithmetic: numerator, divider and tap positions
	localparam int NUM_W     = 16;
	localparam int DIV_W     = 14;
	localparam int DIV_CNT_W = 4;
	localparam int POS_W     = 19;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_HEIGHT = 3'd0,
		REG_IMAGE_WIDTH  = 3'd1,
		REG_KERNEL_ROWS  = 3'd2,
		REG_KERNEL_COLS  = 3'd3,
		REG_PAD_ROWS     = 3'd4,
		REG_PAD_COLS     = 3'd5,
		REG_STRIDE_ROWS  = 3'd6,
		REG_STRIDE_COLS  = 3'd7
	} cfg_reg_t;

	// Controller to datapath
	typedef struct packed {
		logic accept_restart;
		logic accept_advance;
		logic div_load;
		logic div_cols;
		logic div_step;
		logic save_rows;
		logic commit;
		logic emit_error;
		logic emit_addr;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic walk_active;
		logic out_free;
		logic setup_error;
	} dp_status_t;

endpackage

[rtl/i2c_ctrl.sv]
// Controller state machine: sequences restarts, the shared divider and word emission.
module i2c_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_restart,
	output logic               in_ready,
	output i2c_pkg::dp_cmd_t   cmd,
	input  i2c_pkg::dp_status_t status
);
	import i2c_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_ROWS,
		ST_SAVE_ROWS,
		ST_DIV_COLS,
		ST_COMMIT,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 accept;
	logic                 div_last;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid & in_ready;
	assign div_last = (cnt_q == DIV_CNT_W'(DIV_W - 1));

	// Decode commands from the current state
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_restart) begin
					cmd.accept_restart = 1'b1;
					cmd.div_load       = 1'b1;
				end else if (accept && status.walk_active) begin
					cmd.accept_advance = 1'b1;
				end
			end
			ST_DIV_ROWS: cmd.div_step = 1'b1;
			ST_SAVE_ROWS: begin
				cmd.save_rows = 1'b1;
				cmd.div_load  = 1'b1;
				cmd.div_cols  = 1'b1;
			end
			ST_DIV_COLS: cmd.div_step = 1'b1;
			ST_COMMIT: begin
				cmd.commit     = 1'b1;
				cmd.emit_error = status.setup_error & status.out_free;
			end
			ST_EMIT: cmd.emit_addr = status.out_free;
			default: cmd = '0;
		endcase
	end

	// Advance state and step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && in_restart) begin
						state_q <= ST_DIV_ROWS;
					end else if (accept && status.walk_active) begin
						state_q <= ST_EMIT;
					end
				end
				ST_DIV_ROWS: begin
					if (div_last) begin
						cnt_q   <= '0;
						state_q <= ST_SAVE_ROWS;
					end else begin
						cnt_q <= cnt_q + DIV_CNT_W'(1);
					end
				end
				ST_SAVE_ROWS: state_q <= ST_DIV_COLS;
				ST_DIV_COLS: begin
					if (div_last) begin
						cnt_q   <= '0;
						state_q <= ST_COMMIT;
					end else begin
						cnt_q <= cnt_q + DIV_CNT_W'(1);
					end
				end
				ST_COMMIT: begin
					if (!status.setup_error || status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/i2c_datapath.sv]
// Datapath: configuration registers, output-size divider, walk counters and offset arithmetic.
module i2c_datapath #(
	parameter int OFFSET_BITS = i2c_pkg::OFFSET_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [i2c_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [i2c_pkg::CFG_W-1:0]     cfg_data,
	input  logic [i2c_pkg::CH_W-1:0]      in_channels,
	input  i2c_pkg::dp_cmd_t              cmd,
	output i2c_pkg::dp_status_t           status,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [OFFSET_BITS-1:0]        out_offset,
	output logic                          out_zero_fill,
	output logic                          out_last,
	output logic                          out_error
);
	import i2c_pkg::*;

	// Configuration registers
	logic [DIM_W-1:0] height_q, width_q;
	logic [KER_W-1:0] krows_q, kcols_q;
	logic [PAD_W-1:0] prows_q, pcols_q;
	logic [STR_W-1:0] srows_q, scols_q;

	// Walk state
	logic [CH_W-1:0]        chans_q;
	logic [DIM_W-1:0]       out_height_q, out_width_q;
	logic [CHIDX_W-1:0]     ch_idx_q;
	logic [TAP_W-1:0]       tap_row_q, tap_col_q;
	logic [DIM_W-1:0]       orow_q, ocol_q;
	logic [OFFSET_BITS-1:0] base_q;
	logic                   walk_active_q;
	logic [2*DIM_W-1:0]     plane;

	// Divider and row-axis result
	logic [STR_W-1:0]  div_rem_q;
	logic [DIV_W-1:0]  div_quo_q;
	logic              div_cols_q;
	logic              rows_ok_q;
	logic [DIM_W-1:0]  rows_dim_q;

	// Address stage
	logic [POS_W-1:0]       row_s1, col_s1;
	logic                   fin_s1;
	logic [OFFSET_BITS-1:0] base_s1;

	// Output register
	logic                   out_valid_q;
	logic [OFFSET_BITS-1:0] out_offset_q;
	logic                   out_zero_q, out_last_q, out_err_q;

	// Output-size numerators for both axes
	logic [NUM_W-1:0]        span_rows, span_cols;
	logic signed [NUM_W-1:0] num_rows, num_cols, num_sel;
	logic [NUM_W-1:0]        mag_sel;
	logic                    pre_ok_rows, pre_ok_cols, pre_ok_sel;
	logic [STR_W-1:0]        stride_sel;
	logic                    ax_ok;
	logic [DIM_W-1:0]        ax_dim;
	logic [STR_W:0]          div_trial;
	logic                    div_fit;

	always_comb begin
		span_rows = NUM_W'(DILATION_ROWS) * NUM_W'(krows_q - KER_W'(1)) + NUM_W'(1);
		span_cols = NUM_W'(DILATION_COLS) * NUM_W'(kcols_q - KER_W'(1)) + NUM_W'(1);
		num_rows  = $signed(NUM_W'(height_q)) + $signed(NUM_W'({prows_q, 1'b0}))
			- $signed(span_rows);
		num_cols  = $signed(NUM_W'(width_q)) + $signed(NUM_W'({pcols_q, 1'b0}))
			- $signed(span_cols);
		pre_ok_rows = (height_q != '0) && ({4'd0, height_q} <= MAX_DIM_V)
			&& (krows_q != '0) && (krows_q <= KER_W'(MAX_KERNEL)) && (srows_q != '0);
		pre_ok_cols = (width_q != '0) && ({4'd0, width_q} <= MAX_DIM_V)
			&& (kcols_q != '0) && (kcols_q <= KER_W'(MAX_KERNEL)) && (scols_q != '0);
		num_sel    = div_cols_q ? num_cols : num_rows;
		pre_ok_sel = div_cols_q ? pre_ok_cols : pre_ok_rows;
		stride_sel = div_cols_q ? scols_q : srows_q;
		mag_sel    = NUM_W'(-num_sel);
		// A negative numerator truncates to zero only while it is smaller than the stride
		if (num_sel[NUM_W-1]) begin
			ax_ok  = pre_ok_sel && (mag_sel < NUM_W'(stride_sel));
			ax_dim = DIM_W'(1);
		end else begin
			ax_ok  = pre_ok_sel && (div_quo_q <= DIV_W'(OUT_DIM_MAX - 1));
			ax_dim = DIM_W'(div_quo_q + DIV_W'(1));
		end
		div_trial = {div_rem_q, div_quo_q[DIV_W-1]};
		div_fit   = (div_trial >= {1'b0, stride_sel});
	end

	// Plane size of the current image setting, added to the base at each channel step
	assign plane = (2*DIM_W)'(height_q) * (2*DIM_W)'(width_q);

	// Tap position of the current counters
	logic [POS_W-1:0] row_now, col_now;
	logic             fin_now;

	always_comb begin
		row_now = POS_W'(orow_q) * POS_W'(srows_q)
			+ POS_W'(tap_row_q) * POS_W'(DILATION_ROWS) - POS_W'(prows_q);
		col_now = POS_W'(ocol_q) * POS_W'(scols_q)
			+ POS_W'(tap_col_q) * POS_W'(DILATION_COLS) - POS_W'(pcols_q);
		fin_now = (CH_W'({1'b0, ch_idx_q}) + CH_W'(1) == chans_q)
			&& (KER_W'({1'b0, tap_row_q}) + KER_W'(1) == krows_q)
			&& (KER_W'({1'b0, tap_col_q}) + KER_W'(1) == kcols_q)
			&& (orow_q + DIM_W'(1) == out_height_q)
			&& (ocol_q + DIM_W'(1) == out_width_q);
	end

	// Offset of the staged tap
	logic                   tap_in_image;
	logic [2*DIM_W-1:0]     row_lin;
	logic [OFFSET_BITS-1:0] offset_calc;
	logic                   out_free;

	always_comb begin
		tap_in_image = !row_s1[POS_W-1] && (row_s1 < POS_W'(height_q))
			&& !col_s1[POS_W-1] && (col_s1 < POS_W'(width_q));
		row_lin = (2*DIM_W)'(row_s1[DIM_W-1:0]) * (2*DIM_W)'(width_q);
		offset_calc = base_s1 + OFFSET_BITS'(row_lin) + OFFSET_BITS'(col_s1[DIM_W-1:0]);
	end

	assign out_free = !out_valid_q || out_ready;

	// Configuration, walk counters and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q      <= DIM_W'(1);
			width_q       <= DIM_W'(1);
			krows_q       <= KER_W'(1);
			kcols_q       <= KER_W'(1);
			prows_q       <= '0;
			pcols_q       <= '0;
			srows_q       <= STR_W'(1);
			scols_q       <= STR_W'(1);
			chans_q       <= '0;
			out_height_q  <= '0;
			out_width_q   <= '0;
			ch_idx_q      <= '0;
			tap_row_q     <= '0;
			tap_col_q     <= '0;
			orow_q        <= '0;
			ocol_q        <= '0;
			base_q        <= '0;
			walk_active_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_IMAGE_HEIGHT: height_q <= cfg_data;
					REG_IMAGE_WIDTH:  width_q  <= cfg_data;
					REG_KERNEL_ROWS:  krows_q  <= cfg_data[KER_W-1:0];
					REG_KERNEL_COLS:  kcols_q  <= cfg_data[KER_W-1:0];
					REG_PAD_ROWS:     prows_q  <= cfg_data[PAD_W-1:0];
					REG_PAD_COLS:     pcols_q  <= cfg_data[PAD_W-1:0];
					REG_STRIDE_ROWS:  srows_q  <= cfg_data[STR_W-1:0];
					REG_STRIDE_COLS:  scols_q  <= cfg_data[STR_W-1:0];
					default: ;
				endcase
			end

			// Restart: drop the running walk and latch the channel count
			if (cmd.accept_restart) begin
				chans_q       <= (in_channels > CH_W'(MAX_CHANNELS)) ?
					CH_W'(MAX_CHANNELS) : in_channels;
				ch_idx_q      <= '0;
				tap_row_q     <= '0;
				tap_col_q     <= '0;
				orow_q        <= '0;
				ocol_q        <= '0;
				base_q        <= '0;
				walk_active_q <= 1'b0;
			end

			// Commit output sizes, or clear them on an unusable setup
			if (cmd.commit) begin
				if (rows_ok_q && ax_ok) begin
					out_height_q  <= rows_dim_q;
					out_width_q   <= ax_dim;
					walk_active_q <= (chans_q != '0);
				end else begin
					out_height_q  <= '0;
					out_width_q   <= '0;
					chans_q       <= '0;
					walk_active_q <= 1'b0;
				end
			end

			// Advance the walk, output column innermost
			if (cmd.accept_advance) begin
				if (fin_now) begin
					walk_active_q <= 1'b0;
				end else if (ocol_q + DIM_W'(1) < out_width_q) begin
					ocol_q <= ocol_q + DIM_W'(1);
				end else begin
					ocol_q <= '0;
					if (orow_q + DIM_W'(1) < out_height_q) begin
						orow_q <= orow_q + DIM_W'(1);
					end else begin
						orow_q <= '0;
						if (KER_W'({1'b0, tap_col_q}) + KER_W'(1) < kcols_q) begin
							tap_col_q <= tap_col_q + TAP_W'(1);
						end else begin
							tap_col_q <= '0;
							if (KER_W'({1'b0, tap_row_q}) + KER_W'(1) < krows_q) begin
								tap_row_q <= tap_row_q + TAP_W'(1);
							end else begin
								tap_row_q <= '0;
								ch_idx_q  <= ch_idx_q + CHIDX_W'(1);
								base_q    <= base_q + OFFSET_BITS'(plane);
							end
						end
					end
				end
			end

			if (cmd.emit_addr || cmd.emit_error) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Divider, staged tap and output word
	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			div_rem_q  <= '0;
			div_quo_q  <= cmd.div_cols ? num_cols[DIV_W-1:0] : num_rows[DIV_W-1:0];
			div_cols_q <= cmd.div_cols;
		end else if (cmd.div_step) begin
			div_rem_q <= div_fit ? STR_W'(div_trial - {1'b0, stride_sel})
				: div_trial[STR_W-1:0];
			div_quo_q <= {div_quo_q[DIV_W-2:0], div_fit};
		end
		if (cmd.save_rows) begin
			rows_ok_q  <= ax_ok;
			rows_dim_q <= ax_dim;
		end
		if (cmd.accept_advance) begin
			row_s1  <= row_now;
			col_s1  <= col_now;
			fin_s1  <= fin_now;
			base_s1 <= base_q;
		end
		if (cmd.emit_error) begin
			out_offset_q <= '0;
			out_zero_q   <= 1'b0;
			out_last_q   <= 1'b0;
			out_err_q    <= 1'b1;
		end else if (cmd.emit_addr) begin
			out_offset_q <= tap_in_image ? offset_calc : '0;
			out_zero_q   <= !tap_in_image;
			out_last_q   <= fin_s1;
			out_err_q    <= 1'b0;
		end
	end

	assign status.walk_active = walk_active_q;
	assign status.out_free    = out_free;
	assign status.setup_error = !(rows_ok_q && ax_ok);

	assign out_valid     = out_valid_q;
	assign out_offset    = out_offset_q;
	assign out_zero_fill = out_zero_q;
	assign out_last      = out_last_q;
	assign out_error     = out_err_q;

endmodule

[rtl/im2col_address_generator.sv]
// Top level of the im2col address generator: stream ports, controller and datapath.
//
//  port group   | dir | tdata                      | tuser                          | tlast
//  s_axis_*     | in  | [10:0] channel_count       | [0] restart                    | -
//  m_axis_*     | out | [OFFSET_BITS-1:0] offset   | [0] zero_fill, [1] config_error | last
//  cfg_*        | in  | cfg_we, cfg_index, cfg_data: one register write per cycle
//
// An advance word first stages the tap position; once the output is free it forms the offset
// with the row-times-width product and loads the output register.
// A restart word runs the shared divider: 14 steps per axis, one bit a step.
// Reset restores the register defaults and leaves the walk idle.
// A stalled output holds its word; the block waits for it before loading the next.
module im2col_address_generator #(
	parameter int OFFSET_BITS = i2c_pkg::OFFSET_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [i2c_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // [10:0] channel_count
	input  logic [0:0]                           s_axis_tuser,  // [0] restart
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [((OFFSET_BITS+7)/8)*8-1:0]     m_axis_tdata,  // source_offset
	output logic                                 m_axis_tlast,
	output logic [1:0]                           m_axis_tuser,  // [0] zero_fill, [1] config_error
	input  logic                                 cfg_we,
	input  logic [i2c_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [i2c_pkg::CFG_W-1:0]            cfg_data
);
	import i2c_pkg::*;

	localparam int OUT_DATA_W = ((OFFSET_BITS + 7) / 8) * 8;

	dp_cmd_t                cmd;
	dp_status_t             status;
	logic [OFFSET_BITS-1:0] offset;
	logic                   zero_fill, config_error;

	i2c_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_restart (s_axis_tuser[0]),
		.in_ready   (s_axis_tready),
		.cmd        (cmd),
		.status     (status)
	);

	i2c_datapath #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_channels   (s_axis_tdata[CH_W-1:0]),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_offset    (offset),
		.out_zero_fill (zero_fill),
		.out_last      (m_axis_tlast),
		.out_error     (config_error)
	);

	assign m_axis_tdata = OUT_DATA_W'(offset);
	assign m_axis_tuser = {config_error, zero_fill};

endmodule

[rtl/i2c_checker.sv]
// Port-level checker of the im2col address generator and its bind.
`include "assert_macros.svh"

module i2c_checker #(
	parameter int OFFSET_BITS = i2c_pkg::OFFSET_BITS_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [0:0]                       s_axis_tuser,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [((OFFSET_BITS+7)/8)*8-1:0] m_axis_tdata,
	input logic                             m_axis_tlast,
	input logic [1:0]                       m_axis_tuser
);

	// Hold a stalled word
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output word changed")

	// Error words carry nothing else
	`ASSERT_IMPLIES(a_err_clean, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], !m_axis_tlast && !m_axis_tuser[0] && (m_axis_tdata == '0), "error word carries other fields")

	// Padding taps carry a zero offset
	`ASSERT_IMPLIES(a_fill_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "padding tap has a non-zero offset")

	// A restart busies the input while the output sizes are worked out
	`ASSERT_NEXT(a_restart_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser[0], !s_axis_tready, "input ready right after a restart")

endmodule

bind im2col_address_generator i2c_checker #(
	.OFFSET_BITS (OFFSET_BITS)
) u_i2c_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

[tb/sv/tb.sv]
// Self-checking stream testbench for the im2col address generator: driver, monitor, predictor.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2c_pkg::*;

	localparam int STALL_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 64;
	localparam int ITEM_TARGET   = 1600;
	localparam int MAX_REPORTS   = 100;
	localparam int FULL_WALK_MAX = 150;

	// One input word: restart flag and channel count
	typedef struct packed {
		logic        restart;
		logic [10:0] channels;
	} walk_cmd_t;

	// One column-buffer word as the block should emit it
	typedef struct packed {
		logic [31:0] offset;
		logic        zero_fill;
		logic        last;
		logic        cfg_err;
	} col_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;   // [10:0] channel_count
	logic [0:0]           s_axis_tuser = '0;   // [0] restart
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [31:0]          m_axis_tdata;        // source_offset
	logic                 m_axis_tlast;
	logic [1:0]           m_axis_tuser;        // [0] zero_fill, [1] config_error
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	im2col_address_generator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	walk_cmd_t pending_cmds[$];
	col_word_t expected_words[$];
	int        queued_words = 0;
	int        taken_words = 0;
	int        errors = 0;
	int        idle_mode = 0;   // 0 none, 1 sender idle, 2 receiver stall, 3 both lightly
	int        stim_count = 0;

	// Register copy, reset values first; next_geom stages a phase's setting
	int geom [8] = '{1, 1, 1, 1, 0, 0, 1, 1};
	int next_geom [8];

	// Walk state of the predictor
	int          ch_total = 0;
	int          oh = 0;
	int          ow = 0;
	int          ch_idx = 0;
	int          t_row = 0;
	int          t_col = 0;
	int          o_row = 0;
	int          o_col = 0;
	logic [31:0] ch_base = '0;
	logic        walking = 1'b0;

	function automatic int reg_mask(cfg_reg_t idx);
		case (idx)
			REG_IMAGE_HEIGHT, REG_IMAGE_WIDTH: return 13'h1FFF;
			REG_PAD_ROWS, REG_PAD_COLS:        return 4'hF;
			default:                           return 5'h1F;
		endcase
	endfunction

	// Output size along one axis, -1 when the setting is unusable
	function automatic int axis_len(int dim, int kern, int pad, int stride, int dil);
		int num;
		int q;
		if (dim < 1 || dim > MAX_IMAGE_DIM) return -1;
		if (kern < 1 || kern > MAX_KERNEL) return -1;
		if (stride < 1) return -1;
		num = dim + 2 * pad - (dil * (kern - 1) + 1);
		q = num / stride + 1;   // truncates toward zero, also for a negative numerator
		if (q < 1 || q > OUT_DIM_MAX) return -1;
		return q;
	endfunction

	function automatic int rows_out();
		return axis_len(geom[REG_IMAGE_HEIGHT], geom[REG_KERNEL_ROWS], geom[REG_PAD_ROWS],
			geom[REG_STRIDE_ROWS], DILATION_ROWS);
	endfunction

	function automatic int cols_out();
		return axis_len(geom[REG_IMAGE_WIDTH], geom[REG_KERNEL_COLS], geom[REG_PAD_COLS],
			geom[REG_STRIDE_COLS], DILATION_COLS);
	endfunction

	// Number of words a restart with this channel count would yield, -1 on error
	function automatic longint walk_len(int ch);
		int oh_n;
		int ow_n;
		int c;
		oh_n = rows_out();
		ow_n = cols_out();
		if (oh_n < 0 || ow_n < 0) return -1;
		c = (ch > MAX_CHANNELS) ? MAX_CHANNELS : ch;
		return longint'(c) * geom[REG_KERNEL_ROWS] * geom[REG_KERNEL_COLS] * oh_n * ow_n;
	endfunction

	// Advance the walk by one accepted input word, queue any word it causes
	function automatic void predict_walk(walk_cmd_t cmd);
		int          oh_n;
		int          ow_n;
		int          c;
		longint      row;
		longint      col;
		logic        in_image;
		logic        fin;
		col_word_t   w;
		w = '0;
		if (cmd.restart) begin
			oh_n = rows_out();
			ow_n = cols_out();
			ch_idx = 0; t_row = 0; t_col = 0; o_row = 0; o_col = 0; ch_base = '0;
			if (oh_n < 0 || ow_n < 0) begin
				oh = 0; ow = 0; ch_total = 0; walking = 1'b0;
				w.cfg_err = 1'b1;
				expected_words.push_back(w);
			end else begin
				c = (int'(cmd.channels) > MAX_CHANNELS) ? MAX_CHANNELS : int'(cmd.channels);
				ch_total = c; oh = oh_n; ow = ow_n;
				walking = (c != 0);
			end
			return;
		end
		if (!walking) return;

		row = longint'(o_row) * geom[REG_STRIDE_ROWS] - geom[REG_PAD_ROWS] + t_row * DILATION_ROWS;
		col = longint'(o_col) * geom[REG_STRIDE_COLS] - geom[REG_PAD_COLS] + t_col * DILATION_COLS;
		in_image = row >= 0 && row < geom[REG_IMAGE_HEIGHT] && col >= 0 && col < geom[REG_IMAGE_WIDTH];
		fin = (ch_idx + 1 == ch_total) && (t_row + 1 == geom[REG_KERNEL_ROWS])
			&& (t_col + 1 == geom[REG_KERNEL_COLS]) && (o_row + 1 == oh) && (o_col + 1 == ow);
		w.offset = in_image ? 32'(longint'(ch_base) + row * geom[REG_IMAGE_WIDTH] + col) : 32'd0;
		w.zero_fill = !in_image;
		w.last = fin;
		expected_words.push_back(w);

		// Step output column, output row, tap column, tap row, channel in that order
		if (fin) begin
			walking = 1'b0;
		end else begin
			o_col++;
			if (o_col >= ow) begin
				o_col = 0;
				o_row++;
				if (o_row >= oh) begin
					o_row = 0;
					t_col++;
					if (t_col >= geom[REG_KERNEL_COLS]) begin
						t_col = 0;
						t_row++;
						if (t_row >= geom[REG_KERNEL_ROWS]) begin
							t_row = 0;
							ch_idx++;
							ch_base = 32'(longint'(ch_base)
								+ longint'(geom[REG_IMAGE_HEIGHT]) * geom[REG_IMAGE_WIDTH]);
						end
					end
				end
			end
		end
	endfunction

	function automatic void flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
		errors++;
		if (errors <= MAX_REPORTS)
			$error("%s: expected %0d, got %0d", field, want, got);
	endfunction

	// Feed input words from the pending queue, idling at random per phase
	always @(posedge clk) begin : drive_inputs
		walk_cmd_t cmd;
		int        idle_pct;
		idle_pct = (idle_mode == 1) ? 78 : (idle_mode == 3) ? 20 : 0;
		if (arst_n && (!s_axis_tvalid || s_axis_tready)) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
				cmd = pending_cmds.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {{(IN_DATA_W-11){1'b0}}, cmd.channels};
				s_axis_tuser  <= cmd.restart;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Stall the output side at random per phase
	always @(posedge clk) begin : drive_ready
		int stall_pct;
		stall_pct = (idle_mode == 2) ? 78 : (idle_mode == 3) ? 20 : 0;
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Predict on every accepted input word, check every accepted output word
	always @(posedge clk) begin : track_words
		col_word_t want;
		walk_cmd_t got_cmd;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				got_cmd.restart  = s_axis_tuser[0];
				got_cmd.channels = s_axis_tdata[10:0];
				predict_walk(got_cmd);
				taken_words++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$error("unexpected word: source_offset %0d zero_fill %0b last %0b config_error %0b",
							m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]);
				end else begin
					want = expected_words.pop_front();
					if (m_axis_tdata !== want.offset)
						flag_mismatch("source_offset", want.offset, m_axis_tdata);
					if (m_axis_tuser[0] !== want.zero_fill)
						flag_mismatch("zero_fill", want.zero_fill, m_axis_tuser[0]);
					if (m_axis_tlast !== want.last)
						flag_mismatch("last", want.last, m_axis_tlast);
					if (m_axis_tuser[1] !== want.cfg_err)
						flag_mismatch("config_error", want.cfg_err, m_axis_tuser[1]);
				end
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin : watchdog
		int quiet;
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic push_cmd(logic restart, int ch);
		walk_cmd_t cmd;
		cmd.restart = restart;
		cmd.channels = 11'(ch);
		pending_cmds.push_back(cmd);
		queued_words++;
	endtask

	// Wait for every word to be taken and answered, then let the block go quiet
	task automatic settle();
		while (taken_words != queued_words || expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all eight registers from next_geom on consecutive cycles
	task automatic apply_geometry();
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= CFG_W'(next_geom[i]);
			geom[i] = next_geom[i] & reg_mask(cfg_reg_t'(i));
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic stage_geometry(int h, int w, int kr, int kc, int pr, int pc, int sr, int sc);
		next_geom[REG_IMAGE_HEIGHT] = h;
		next_geom[REG_IMAGE_WIDTH]  = w;
		next_geom[REG_KERNEL_ROWS]  = kr;
		next_geom[REG_KERNEL_COLS]  = kc;
		next_geom[REG_PAD_ROWS]     = pr;
		next_geom[REG_PAD_COLS]     = pc;
		next_geom[REG_STRIDE_ROWS]  = sr;
		next_geom[REG_STRIDE_COLS]  = sc;
	endtask

	initial begin : stimulus
		int     phase_items;
		int     ch;
		int     n;
		int     pick;
		longint len;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry: idle advance, single word walk, empty walk, clamped count, restart mid-walk
		idle_mode = 0;
		push_cmd(1'b0, 0);
		push_cmd(1'b1, 1);
		push_cmd(1'b0, 0);
		push_cmd(1'b0, 0);
		push_cmd(1'b1, 0);
		push_cmd(1'b0, 0);
		push_cmd(1'b1, 2047);
		push_cmd(1'b0, 0);
		push_cmd(1'b0, 0);
		push_cmd(1'b1, 2);
		push_cmd(1'b0, 0);
		push_cmd(1'b0, 0);
		settle();

		// Negative numerator that truncates to one output position
		stage_geometry(1, 1, 2, 2, 0, 0, 2, 2);
		apply_geometry();
		push_cmd(1'b1, 1);
		repeat (4) push_cmd(1'b0, 0);
		settle();

		// Image, kernel and padding registers at their top values, strides at 16, full channel count
		stage_geometry(MAX_IMAGE_DIM, MAX_IMAGE_DIM, 16, 16, 15, 15, 16, 16);
		apply_geometry();
		push_cmd(1'b1, MAX_CHANNELS);
		repeat (3) push_cmd(1'b0, 0);
		settle();

		// Kernel taller than the image: error word, then advance while idle
		stage_geometry(3, 3, 16, 1, 0, 0, 1, 1);
		apply_geometry();
		push_cmd(1'b1, 1);
		push_cmd(1'b0, 0);
		settle();
		stim_count = 23;

		for (int phase = 0; stim_count < ITEM_TARGET; phase++) begin
			idle_mode = phase % 4;
			pick = $urandom_range(9);
			if (pick == 0) begin
				// Raw register contents: out-of-range and masked bits
				for (int i = 0; i < 8; i++)
					next_geom[i] = $urandom_range(13'h1FFF);
			end else if (pick == 1) begin
				// Each register at its low or high end, strides at 1 or 16
				for (int i = 0; i < 8; i++) begin
					case (cfg_reg_t'(i))
						REG_IMAGE_HEIGHT, REG_IMAGE_WIDTH:
							next_geom[i] = $urandom_range(1) ? MAX_IMAGE_DIM : 1;
						REG_PAD_ROWS, REG_PAD_COLS:
							next_geom[i] = $urandom_range(1) ? 15 : 0;
						default:
							next_geom[i] = $urandom_range(1) ? 16 : 1;
					endcase
				end
			end else begin
				stage_geometry($urandom_range(1, 8), $urandom_range(1, 8),
					$urandom_range(1, 3), $urandom_range(1, 3),
					$urandom_range(0, 2), $urandom_range(0, 2),
					$urandom_range(1, 3), $urandom_range(1, 3));
			end
			apply_geometry();

			phase_items = 0;
			while (phase_items < 100) begin
				if ($urandom_range(9) < 7) begin
					// Well-formed walk with random content
					ch = $urandom_range(1, 3);
					len = walk_len(ch);
					push_cmd(1'b1, ch);
					phase_items++;
					if (len < 0) begin
						push_cmd(1'b0, 0);
					end else if (len <= FULL_WALK_MAX) begin
						repeat (int'(len)) push_cmd(1'b0, 0);
						phase_items += int'(len);
						if ($urandom_range(3) == 0) push_cmd(1'b0, 0);
					end else begin
						// Long walk: cut short by the next restart
						n = $urandom_range(1, 40);
						repeat (n) push_cmd(1'b0, 0);
						phase_items += n;
					end
				end else begin
					// Noise: random restarts and advances with any channel count
					n = $urandom_range(1, 6);
					for (int k = 0; k < n; k++) begin
						push_cmd($urandom_range(3) == 0, $urandom_range(2047));
						phase_items++;
					end
				end
			end
			stim_count += phase_items;
			settle();
		end

		if (errors == 0 && expected_words.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
